>>> design/i64alu_pkg.sv
// Shared types and operation codes for the 64-bit integer ALU.
package i64alu_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_NOT = 3'd3,
        OP_MUL = 3'd4,
        OP_DIV = 3'd5,
        OP_GEU = 3'd6,
        OP_NOP = 3'd7
    } op_t;

endpackage

>>> design/i64alu_div.sv
// Pipelined restoring divider, a fixed number of quotient bits per stage.
module i64alu_div #(
    parameter int W = 64,
    parameter int BITS_PER_STAGE = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         out_valid,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    import i64alu_pkg::*;

    localparam int STAGES = (W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    logic [STAGES:1]       v_reg;
    logic [W-1:0]          q_reg [1:STAGES];   // quotient bits shift in, dividend shifts out
    logic [W-1:0]          r_reg [1:STAGES];
    logic [W-1:0]          d_reg [1:STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic         v_in;
        logic [W-1:0] q_in;
        logic [W-1:0] r_in;
        logic [W-1:0] d_in;
        logic [W-1:0] q_next;
        logic [W-1:0] r_next;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign q_in = dividend;
            assign r_in = '0;
            assign d_in = divisor;
        end
        else
        begin : g_rest
            assign v_in = v_reg[s];
            assign q_in = q_reg[s];
            assign r_in = r_reg[s];
            assign d_in = d_reg[s];
        end

        always_comb
        begin
            logic [W:0] trial;
            trial = '0;
            q_next = q_in;
            r_next = r_in;
            for (int k = 0; k < BITS_PER_STAGE; k++)
            begin
                if (s * BITS_PER_STAGE + k < W)
                begin
                    trial = {r_next, q_next[W-1]};
                    q_next = {q_next[W-2:0], 1'b0};
                    if (trial >= {1'b0, d_in})
                    begin
                        trial = trial - {1'b0, d_in};
                        q_next[0] = 1'b1;
                    end
                    r_next = trial[W-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            q_reg[s+1] <= q_next;
            r_reg[s+1] <= r_next;
            d_reg[s+1] <= d_in;
        end
    end

    // divisor zero falls out naturally: all trials pass, remainder is dividend
    assign out_valid = v_reg[STAGES];
    assign quotient  = q_reg[STAGES];
    assign remainder = r_reg[STAGES];

endmodule

>>> design/int64_alu_add_sub_mul_divmod.sv
// Top level of the pipelined 64-bit integer ALU.
//
// Usage: drive operation, operand_a, operand_b, carry_in and raise start.
// busy is always low, so a transfer happens on every cycle start is high;
// one operation may enter per clock.
// Each item yields one result, shown for exactly one cycle with done high
// on result_value, remainder_value and flag_out. Results leave in order.
// Latency is the same for all operations, set by the divider pipeline
// retiring 8 quotient bits per stage; other operations ride a matching
// delay line. The multiplier is cut into 32x32 partial products over
// two stages.
// Throughput: one item per cycle.
// Reset clears all valid bits; in-flight items are dropped.
// The receiver cannot stall; results must be taken when done is high.
module int64_alu_add_sub_mul_divmod #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            operation,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    input  logic                  carry_in,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic [DATA_WIDTH-1:0] remainder_value,
    output logic                  flag_out
);
    import i64alu_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int H      = (W + 1) / 2;
    localparam int DSTG   = (W + 7) / 8;
    localparam int DLY    = DSTG;  // delay-line length, one per divider stage

    assign busy = 1'b0;

    // stage 1: simple ops and partial products
    logic         v1_reg;
    op_t          op1_reg;
    logic [W-1:0] a1_reg, b1_reg, simple1_reg;
    logic         flag1_reg;
    logic [2*H-1:0] pll_reg;
    logic [2*H-1:0] plh_reg, phl_reg;

    logic [2*H-1:0] a_ext, b_ext;
    logic [W-1:0]   simple_next;
    logic           flag_next;
    logic [W:0]     sum_wide;

    always_comb
    begin
        a_ext = (2*H)'(operand_a);
        b_ext = (2*H)'(operand_b);
        sum_wide = {1'b0, operand_a} + {1'b0, operand_b} + {{W{1'b0}}, carry_in};
        simple_next = '0;
        flag_next = 1'b0;
        unique case (op_t'(operation))
            OP_ADD:
            begin
                simple_next = sum_wide[W-1:0];
                flag_next = sum_wide[W];
            end
            OP_SUB: simple_next = operand_a - operand_b;
            OP_NEG: simple_next = '0 - operand_a;
            OP_NOT: simple_next = ~operand_a;
            OP_GEU: flag_next = (operand_a >= operand_b);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        op1_reg     <= op_t'(operation);
        a1_reg      <= operand_a;
        b1_reg      <= operand_b;
        simple1_reg <= simple_next;
        flag1_reg   <= flag_next;
        pll_reg     <= a_ext[H-1:0] * b_ext[H-1:0];
        plh_reg     <= a_ext[H-1:0] * b_ext[2*H-1:H];
        phl_reg     <= a_ext[2*H-1:H] * b_ext[H-1:0];
    end

    // stage 2: combine partial products (low W bits only)
    logic [2*H-1:0] prod_full;
    logic [W-1:0]   prod2_reg;
    assign prod_full = pll_reg + {plh_reg[H-1:0], {H{1'b0}}} + {phl_reg[H-1:0], {H{1'b0}}};

    always_ff @(posedge clk)
        prod2_reg <= prod_full[W-1:0];

    // divider fed from stage 1 registers
    logic         div_v;
    logic [W-1:0] div_q, div_r;

    i64alu_div #(.W(W), .BITS_PER_STAGE(8)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .dividend  (a1_reg),
        .divisor   (b1_reg),
        .out_valid (div_v),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // delay line for op code and simple results, aligned with divider output
    op_t          opd_reg   [DLY];
    logic [W-1:0] simd_reg  [DLY];
    logic         flagd_reg [DLY];

    always_ff @(posedge clk)
    begin
        opd_reg[0]   <= op1_reg;
        simd_reg[0]  <= (op1_reg == OP_MUL) ? '0 : simple1_reg;
        flagd_reg[0] <= flag1_reg;
        for (int i = 1; i < DLY; i++)
        begin
            opd_reg[i]   <= opd_reg[i-1];
            simd_reg[i]  <= (i == 1 && opd_reg[0] == OP_MUL) ? prod2_reg : simd_reg[i-1];
            flagd_reg[i] <= flagd_reg[i-1];
        end
    end

    // output register
    logic         done_reg;
    logic [W-1:0] res_reg, rem_reg;
    logic         flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_v;
    end

    always_ff @(posedge clk)
    begin
        if (opd_reg[DLY-1] == OP_DIV)
        begin
            res_reg <= div_q;
            rem_reg <= div_r;
        end
        else if (DLY == 1 && opd_reg[DLY-1] == OP_MUL)
        begin
            // single divider stage: product joins at the output register
            res_reg <= prod2_reg;
            rem_reg <= '0;
        end
        else
        begin
            res_reg <= simd_reg[DLY-1];
            rem_reg <= '0;
        end
        flag_reg <= flagd_reg[DLY-1];
    end

    assign done            = done_reg;
    assign result_value    = res_reg;
    assign remainder_value = rem_reg;
    assign flag_out        = flag_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(DLY + 2) done)
        else $error("result missing after fixed latency");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, DLY + 2))
        else $error("result without a transfer");
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && operation == OP_DIV && operand_b == '0) |-> ##(DLY + 2)
        (result_value == '1 && remainder_value == $past(operand_a, DLY + 2)))
        else $error("divide by zero result wrong");
    a_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && operation != OP_DIV) |-> ##(DLY + 2) (remainder_value == '0))
        else $error("remainder not zero");
`endif

endmodule

>>> bench/int64_alu_add_sub_mul_divmod_test.sv
// Self-checking testbench for the 64-bit integer ALU: queued stimulus, predicted results.
`timescale 1ns / 100ps

module int64_alu_add_sub_mul_divmod_test;
    import i64alu_pkg::*;

    localparam int W = 64;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        op_t          op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic         cin;
    } alu_cmd_t;

    typedef struct {
        logic [W-1:0] value;
        logic [W-1:0] rem;
        logic         flag;
    } alu_res_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [2:0]   operation = 3'd0;
    logic [W-1:0] operand_a = '0;
    logic [W-1:0] operand_b = '0;
    logic         carry_in = 1'b0;
    logic         done;
    logic [W-1:0] result_value;
    logic [W-1:0] remainder_value;
    logic         flag_out;

    alu_cmd_t pending_cmds[$];
    alu_res_t expected_results[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       gap_percent = 0;

    int64_alu_add_sub_mul_divmod #(.DATA_WIDTH(W)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
        .carry_in(carry_in), .done(done), .result_value(result_value),
        .remainder_value(remainder_value), .flag_out(flag_out)
    );

    always #5 clk = ~clk;

    function automatic alu_res_t compute_alu(alu_cmd_t c);
        alu_res_t r;
        logic [W:0] sum;
        r.value = '0;
        r.rem = '0;
        r.flag = 1'b0;
        case (c.op)
            OP_ADD:
            begin
                sum = {1'b0, c.a} + {1'b0, c.b} + c.cin;
                r.value = sum[W-1:0];
                r.flag = sum[W];
            end
            OP_SUB: r.value = c.a - c.b;
            OP_NEG: r.value = -c.a;
            OP_NOT: r.value = ~c.a;
            OP_MUL: r.value = c.a * c.b;
            OP_DIV:
            begin
                if (c.b == '0)
                begin
                    r.value = '1;
                    r.rem = c.a;
                end
                else
                begin
                    r.value = c.a / c.b;
                    r.rem = c.a % c.b;
                end
            end
            OP_GEU: r.flag = (c.a >= c.b);
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [W-1:0] rand_word();
        logic [W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2: w = w >> $urandom_range(1, 63);
            3: w = 64'h8000_0000_0000_0000;
            4: w = W'($urandom_range(0, 15));
            default: ;
        endcase
        return w;
    endfunction

    task automatic queue_cmd(op_t op, logic [W-1:0] a, logic [W-1:0] b, logic cin);
        alu_cmd_t c;
        c.op = op;
        c.a = a;
        c.b = b;
        c.cin = cin;
        pending_cmds.push_back(c);
    endtask

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // driver: one transfer per cycle at most; busy held into account
    always @(negedge clk)
    begin
        if (rst_n && !(start && busy))
        begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= gap_percent)
            begin
                alu_cmd_t c;
                c = pending_cmds.pop_front();
                operation <= c.op;
                operand_a <= c.a;
                operand_b <= c.b;
                carry_in <= c.cin;
                start <= 1'b1;
                expected_results.push_back(compute_alu(c));
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && done)
        begin
            alu_res_t e;
            if (expected_results.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result_value !== e.value) report_mismatch("result", result_value, e.value);
                if (remainder_value !== e.rem) report_mismatch("remainder", remainder_value, e.rem);
                if (flag_out !== e.flag) report_mismatch("flag", W'(flag_out), W'(e.flag));
            end
        end
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [W-1:0] a;
        logic [W-1:0] b;
        // directed: extremes, every code, divide by zero, carry-in ignored elsewhere
        queue_cmd(OP_ADD, '1, '1, 1'b1);
        queue_cmd(OP_ADD, '1, '0, 1'b1);
        queue_cmd(OP_ADD, '0, '0, 1'b0);
        queue_cmd(OP_SUB, '0, 64'd1, 1'b1);
        queue_cmd(OP_SUB, '1, '1, 1'b0);
        queue_cmd(OP_NEG, '0, '1, 1'b1);
        queue_cmd(OP_NEG, 64'h8000_0000_0000_0000, '0, 1'b0);
        queue_cmd(OP_NOT, '0, '0, 1'b1);
        queue_cmd(OP_NOT, '1, '1, 1'b0);
        queue_cmd(OP_MUL, '1, '1, 1'b1);
        queue_cmd(OP_MUL, 64'hffff_ffff, 64'hffff_ffff, 1'b0);
        queue_cmd(OP_DIV, '1, '0, 1'b1);
        queue_cmd(OP_DIV, '0, '0, 1'b0);
        queue_cmd(OP_DIV, '1, 64'd1, 1'b0);
        queue_cmd(OP_DIV, 64'd5, '1, 1'b0);
        queue_cmd(OP_DIV, '1, 64'h8000_0000_0000_0000, 1'b1);
        queue_cmd(OP_GEU, '1, '1, 1'b1);
        queue_cmd(OP_GEU, '0, '1, 1'b0);
        queue_cmd(OP_GEU, '1, '0, 1'b0);
        queue_cmd(OP_NOP, '1, '1, 1'b1);
        for (int i = 0; i < 1400; i++)
        begin
            a = rand_word();
            b = rand_word();
            queue_cmd(op_t'($urandom_range(0, 7)), a, b, 1'($urandom_range(0, 1)));
        end
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        gap_percent = 22;
        wait (pending_cmds.size() < 950);
        gap_percent = 49;
        wait (pending_cmds.size() < 480);
        gap_percent = 0;
        wait (pending_cmds.size() == 0);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
